// ===== rtl/core/ktr_pkg.sv =====
package ktr_pkg;

  localparam int unsigned NumKeys   = 256;
  localparam int unsigned KeyAddrW  = $clog2(NumKeys);
  localparam int unsigned KeyCodeW  = 8;
  localparam int unsigned DeltaW    = 20;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgTimeW  = 24;
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned KindW     = 2;
  localparam int unsigned EntryW    = TimeW + 1;

  localparam logic [KindW-1:0] KIND_PRESSED  = 2'd0;
  localparam logic [KindW-1:0] KIND_RELEASED = 2'd1;
  localparam logic [KindW-1:0] KIND_REPEAT   = 2'd2;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [CfgIndexW-1:0] CFG_INITIAL_DELAY   = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_REPEAT_INTERVAL = 4'd1;

  localparam logic [CfgTimeW-1:0] INITIAL_DELAY_RST   = 24'd500000;
  localparam logic [CfgTimeW-1:0] REPEAT_INTERVAL_RST = 24'd33000;

  typedef struct packed {
    logic                opcode;
    logic [KeyCodeW-1:0] key_code;
    logic                key_pressed;
    logic                key_released;
    logic                key_held;
    logic [DeltaW-1:0]   delta_time_us;
  } in_t;

  typedef struct packed {
    logic [KeyCodeW-1:0] event_key;
    logic [KindW-1:0]    event_kind;
  } out_t;

  // One stored key entry.
  typedef struct packed {
    logic             active;
    logic [TimeW-1:0] elapsed;
  } entry_t;

  // Outcome of one key update.
  typedef struct packed {
    entry_t           entry;
    logic             emit;
    logic [KindW-1:0] kind;
  } upd_t;

  // Pointer-button codes carry no keyboard state.
  function automatic logic is_pointer_button(input logic [KeyCodeW-1:0] code);
    return (code == 8'd1) || (code == 8'd2) || (code == 8'd4) ||
           (code == 8'd5) || (code == 8'd6);
  endfunction

endpackage

// ===== rtl/core/ktr_ram.sv =====
module ktr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ktr_update.sv =====
module ktr_update (
  input  ktr_pkg::entry_t                  entry_i,
  input  logic                             pressed_i,
  input  logic                             released_i,
  input  logic                             held_i,
  input  logic [ktr_pkg::DeltaW-1:0]       delta_i,
  input  logic [ktr_pkg::CfgTimeW-1:0]     delay_i,
  input  logic [ktr_pkg::CfgTimeW-1:0]     interval_i,
  output ktr_pkg::upd_t                    upd_o
);
  import ktr_pkg::*;

  logic [TimeW:0]   sum;
  logic [TimeW-1:0] t_sat;
  logic [TimeW-1:0] delay_w;
  logic [TimeW-1:0] interval_w;

  assign sum        = {1'b0, entry_i.elapsed} + (TimeW + 1)'(delta_i);
  assign t_sat      = sum[TimeW] ? '1 : sum[TimeW-1:0];
  assign delay_w    = TimeW'(delay_i);
  assign interval_w = TimeW'(interval_i);

  always_comb begin
    upd_o               = '0;
    upd_o.entry.active  = entry_i.active;
    upd_o.entry.elapsed = t_sat;
    if (pressed_i || released_i) begin
      // drop the timer on any edge; pressed wins
      upd_o.entry = '0;
      upd_o.emit  = 1'b1;
      upd_o.kind  = pressed_i ? KIND_PRESSED : KIND_RELEASED;
    end else if (held_i) begin
      if (!entry_i.active) begin
        if (t_sat >= delay_w) begin
          upd_o.entry.active  = 1'b1;
          upd_o.entry.elapsed = '0;
          upd_o.emit          = 1'b1;
          upd_o.kind          = KIND_REPEAT;
        end
      end else if (t_sat >= interval_w) begin
        upd_o.entry.elapsed = t_sat - interval_w;
        upd_o.emit          = 1'b1;
        upd_o.kind          = KIND_REPEAT;
      end
    end else begin
      upd_o.entry = '0;
    end
  end

endmodule

// ===== rtl/core/key_typematic_repeat_unit.sv =====
// A key update reads its entry at accept, then loads any event into the output
// register at write-back; no new update is taken until that read-modify-write on
// the single key-state RAM ends (the modify state holds while the output is full).
// A clear transaction drops every per-key valid bit at once.
// Reset: asynchronous, active low; valid bits drop so every key reads as zero,
// delay and interval registers return to 500000 us and 33000 us. No clearing pass.
module key_typematic_repeat_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ktr_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ktr_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ktr_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [ktr_pkg::CfgTimeW-1:0]   cfg_data_i
);
  import ktr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  logic                state_q, state_d;
  logic [NumKeys-1:0]  valid_q, valid_d;
  logic [CfgTimeW-1:0] delay_q, interval_q;
  in_t                 item_q;
  logic                out_valid_q, out_valid_d;
  out_t                out_q;

  logic                in_fire;
  logic                key_ok;
  logic                start_rmw;
  logic [KeyAddrW-1:0] in_addr;
  logic [KeyAddrW-1:0] item_addr;
  logic [EntryW-1:0]   rdata;
  entry_t              cur_entry;
  upd_t                upd;
  logic                stall;
  logic                load_out;
  logic                ram_we;

  // Configuration is always taken; write it only while the block is idle (the block itself does not enforce this).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= INITIAL_DELAY_RST;
      interval_q <= REPEAT_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INITIAL_DELAY:   delay_q    <= cfg_data_i;
        CFG_REPEAT_INTERVAL: interval_q <= cfg_data_i;
        default: ;  // ignore writes beyond the register list
      endcase
    end
  end

  // Input side: take one transaction at a time, only when idle.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_addr    = in_data_i.key_code[KeyAddrW-1:0];
  assign key_ok     = ({1'b0, in_data_i.key_code} < (KeyCodeW + 1)'(NumKeys)) &&
                      !is_pointer_button(in_data_i.key_code);
  assign start_rmw  = in_fire && (in_data_i.opcode == OP_UPDATE) && key_ok;

  always_ff @(posedge clk_i) begin
    if (start_rmw) begin
      item_q <= in_data_i;
    end
  end

  assign item_addr = item_q.key_code[KeyAddrW-1:0];

  // Key state store: elapsed time and active bit, read at accept.
  ktr_ram #(
    .Width (EntryW),
    .Depth (NumKeys)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_addr),
    .wdata_i (upd.entry),
    .re_i    (start_rmw),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // An entry never written since reset or the last clear reads as zero.
  assign cur_entry = valid_q[item_addr] ? entry_t'(rdata) : '0;

  ktr_update u_update (
    .entry_i    (cur_entry),
    .pressed_i  (item_q.key_pressed),
    .released_i (item_q.key_released),
    .held_i     (item_q.key_held),
    .delta_i    (item_q.delta_time_us),
    .delay_i    (delay_q),
    .interval_i (interval_q),
    .upd_o      (upd)
  );

  // Hold the modify stage while an event waits on a full output register.
  assign stall    = upd.emit && out_valid_q && !out_ready_i;
  assign ram_we   = (state_q == ST_MOD) && !stall;
  assign load_out = ram_we && upd.emit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_rmw) state_d = ST_MOD;
      ST_MOD:  if (!stall) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (in_fire && (in_data_i.opcode == OP_CLEAR)) begin
      valid_d = '0;
    end else if (ram_we) begin
      valid_d[item_addr] = 1'b1;
    end
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.event_key  <= item_q.key_code;
      out_q.event_kind <= upd.kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A key update must reach the modify stage the cycle after its read.
  a_rmw_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_rmw |=> (state_q == ST_MOD))
    else $error("read not followed by modify stage");

  // Write back only from the modify stage.
  a_write_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_MOD))
    else $error("state write outside modify stage");

  // A clear leaves every key reading as zero.
  a_clear_drops_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.opcode == OP_CLEAR)) |=> (valid_q == '0))
    else $error("clear left valid bits set");

  // A loaded event is never a code outside the three kinds.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_q.event_kind == KIND_PRESSED ||
                  out_q.event_kind == KIND_RELEASED ||
                  out_q.event_kind == KIND_REPEAT))
    else $error("illegal event kind loaded");
`endif

endmodule

// ===== test/key_typematic_repeat_unit_tb_pkg.sv =====
package ktr_tb_pkg;

  import ktr_pkg::*;

  // Key codes that belong to pointer buttons and never touch key state.
  function automatic bit pointer_code(input logic [KeyCodeW-1:0] code);
    return (code == 8'd1) || (code == 8'd2) || (code == 8'd4) ||
           (code == 8'd5) || (code == 8'd6);
  endfunction

  // Mirror of the per-key repeat state plus the queue of events still owed.
  class repeat_event_board;

    logic [TimeW-1:0]    held_time [NumKeys];
    bit                  repeat_on [NumKeys];
    logic [CfgTimeW-1:0] first_delay;
    logic [CfgTimeW-1:0] next_interval;
    out_t                owed_events [$];
    int unsigned         mismatches;

    function new();
      first_delay   = INITIAL_DELAY_RST;
      next_interval = REPEAT_INTERVAL_RST;
      mismatches    = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (held_time[k]) begin
        held_time[k] = '0;
        repeat_on[k] = 1'b0;
      end
    endfunction

    function void write_register(input logic [CfgIndexW-1:0] idx,
                                 input logic [CfgTimeW-1:0] value);
      if (idx == CFG_INITIAL_DELAY) begin
        first_delay = value;
      end else if (idx == CFG_REPEAT_INTERVAL) begin
        next_interval = value;
      end
    endfunction

    // Work out what one accepted update transaction must produce.
    function void note_update(input in_t item);
      logic [TimeW:0]      sum;
      logic [TimeW-1:0]    t;
      logic [KeyCodeW-1:0] code;
      bit                  emit;
      out_t                ev;
      if (item.opcode == OP_CLEAR) begin
        wipe();
        return;
      end
      code = item.key_code;
      if (int'(code) >= int'(NumKeys) || pointer_code(code)) return;
      emit          = 1'b0;
      ev.event_key  = code;
      ev.event_kind = KIND_REPEAT;
      if (item.key_pressed || item.key_released) begin
        held_time[code] = '0;
        repeat_on[code] = 1'b0;
        ev.event_kind   = item.key_pressed ? KIND_PRESSED : KIND_RELEASED;
        emit            = 1'b1;
      end else if (item.key_held) begin
        sum = {1'b0, held_time[code]} + {{(TimeW+1-DeltaW){1'b0}}, item.delta_time_us};
        t   = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
        if (!repeat_on[code]) begin
          if (t >= {{(TimeW-CfgTimeW){1'b0}}, first_delay}) begin
            repeat_on[code] = 1'b1;
            held_time[code] = '0;
            emit            = 1'b1;
          end else begin
            held_time[code] = t;
          end
        end else if (t >= {{(TimeW-CfgTimeW){1'b0}}, next_interval}) begin
          held_time[code] = t - {{(TimeW-CfgTimeW){1'b0}}, next_interval};
          emit            = 1'b1;
        end else begin
          held_time[code] = t;
        end
      end else begin
        held_time[code] = '0;
        repeat_on[code] = 1'b0;
      end
      if (emit) owed_events.insert(owed_events.size(), ev);
    endfunction

    function void check_event(input out_t seen);
      out_t want;
      if (owed_events.size() == 0) begin
        mismatches++;
        $error("unexpected event: event_key %0d event_kind %0d",
               seen.event_key, seen.event_kind);
        return;
      end
      want = owed_events.pop_front();
      if (seen.event_key !== want.event_key) begin
        mismatches++;
        $error("event_key: expected %0d, actual %0d", want.event_key, seen.event_key);
      end
      if (seen.event_kind !== want.event_kind) begin
        mismatches++;
        $error("event_kind: expected %0d, actual %0d", want.event_kind, seen.event_kind);
      end
    endfunction

    function int unsigned outstanding();
      return owed_events.size();
    endfunction

  endclass

endpackage

// ===== test/key_typematic_repeat_unit_tb.sv =====
module key_typematic_repeat_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ktr_pkg::*;
  import ktr_tb_pkg::*;

  localparam int unsigned MaxGap      = 17;
  localparam int unsigned DrainCycles = 6;
  // Roughly 1100 transactions in all, each allowed a full sender gap, a full
  // receiver stall and the block's own turnaround, then taken four times over.
  localparam int unsigned CycleLimit  = 1200 * (2 * MaxGap + 6) * 4;
  localparam logic [DeltaW-1:0]   DeltaMax = {DeltaW{1'b1}};
  localparam logic [CfgTimeW-1:0] TimeMax  = {CfgTimeW{1'b1}};
  // Enough full-size frames on one key to build its timer past a full interval.
  localparam int unsigned PileFrames = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgTimeW-1:0]  cfg_data_i;

  repeat_event_board board;
  int unsigned       cycle_count = 0;
  // Steady stretches: while set, that side runs back to back without gaps.
  bit                in_steady   = 1'b0;
  bit                out_steady  = 1'b0;
  bit                no_idle     = 1'b0;
  logic [KeyCodeW-1:0] key_pool [8];

  key_typematic_repeat_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: give up once the run has overstayed any plausible length.
  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Sample both handshakes on the edge. Check the outgoing event before noting
  // the incoming transaction, so an event can never match its own cause.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_event(out_data_o);
      if (in_valid_i && in_ready_o) board.note_update(in_data_i);
    end
  end

  // Event sink: stall a random number of cycles ahead of each event, with
  // occasional steady stretches where ready stays high throughout.
  initial begin : event_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = (out_steady || no_idle) ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Present one update transaction and hold it until accepted. Valid is left
  // high afterwards so a back-to-back follower never drops it.
  task automatic send_item(input in_t item);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = (in_steady || no_idle) ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_update(input logic [KeyCodeW-1:0] code, input bit pressed,
                             input bit released, input bit held,
                             input logic [DeltaW-1:0] dt);
    in_t item;
    item.opcode        = OP_UPDATE;
    item.key_code      = code;
    item.key_pressed   = pressed;
    item.key_released  = released;
    item.key_held      = held;
    item.delta_time_us = dt;
    send_item(item);
  endtask

  // Drop input valid, let the last transaction be noted, wait for every owed
  // event, then let the pipe run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0 || out_valid_o) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leave cfg_valid_i high on return; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx,
                           input logic [CfgTimeW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, value);
  endtask

  // Reprogram both timing registers with the block idle, plus one write to an
  // unmapped index that must leave everything alone.
  task automatic program_block(input logic [CfgTimeW-1:0] delay,
                               input logic [CfgTimeW-1:0] interval);
    logic [CfgIndexW-1:0] spare;
    logic [31:0]          junk;
    settle();
    spare = CfgIndexW'($urandom_range(int'(CFG_REPEAT_INTERVAL) + 1,
                                      (1 << CfgIndexW) - 1));
    junk  = $urandom;
    write_reg(CFG_INITIAL_DELAY, delay);
    write_reg(CFG_REPEAT_INTERVAL, interval);
    write_reg(spare, junk[CfgTimeW-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  // Frame time: mostly bounded by the phase cap, with corners and full range.
  function automatic logic [DeltaW-1:0] pick_delta(input int unsigned cap);
    logic [31:0] raw;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    raw  = $urandom;
    if (pick == 0) return '0;
    if (pick == 1) return DeltaMax;
    if (pick == 2) return raw[DeltaW-1:0];
    raw = $urandom_range(0, cap);
    return raw[DeltaW-1:0];
  endfunction

  // Mostly held frames on a small set of keys so timers run up to repeats;
  // edges at the phase's rate, and a sprinkling of noise, pointer codes and
  // clears.
  function automatic in_t random_item(input int unsigned cap,
                                      input int unsigned pool_size,
                                      input int unsigned edge_pct);
    in_t         item;
    int unsigned pick;
    item.opcode        = OP_UPDATE;
    item.key_code      = ($urandom_range(0, 9) == 0) ? KeyCodeW'($urandom_range(0, 255))
                                                     : key_pool[$urandom_range(0, pool_size - 1)];
    item.key_pressed   = 1'b0;
    item.key_released  = 1'b0;
    item.key_held      = 1'b1;
    item.delta_time_us = pick_delta(cap);
    if ($urandom_range(0, 99) < edge_pct) begin
      if ($urandom_range(0, 1) == 1) begin
        item.key_pressed  = 1'b1;
        item.key_released = 1'($urandom_range(0, 1));
      end else begin
        item.key_released = 1'b1;
      end
      item.key_held = 1'($urandom_range(0, 1));
      return item;
    end
    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      return item;
    end else if (pick < 93) begin
      item.key_code     = KeyCodeW'($urandom_range(0, 255));
      item.key_pressed  = 1'($urandom_range(0, 1));
      item.key_released = 1'($urandom_range(0, 1));
      item.key_held     = 1'($urandom_range(0, 1));
    end else if (pick < 96) begin
      item.key_held = 1'b0;
    end else if (pick < 99) begin
      case ($urandom_range(0, 4))
        0:       item.key_code = 8'd1;
        1:       item.key_code = 8'd2;
        2:       item.key_code = 8'd4;
        3:       item.key_code = 8'd5;
        default: item.key_code = 8'd6;
      endcase
      item.key_pressed  = 1'($urandom_range(0, 1));
      item.key_released = 1'($urandom_range(0, 1));
      item.key_held     = 1'($urandom_range(0, 1));
    end else begin
      // Clear: every other field is noise.
      item.opcode       = OP_CLEAR;
      item.key_code     = KeyCodeW'($urandom_range(0, 255));
      item.key_pressed  = 1'($urandom_range(0, 1));
      item.key_released = 1'($urandom_range(0, 1));
      item.key_held     = 1'($urandom_range(0, 1));
    end
    return item;
  endfunction

  task automatic run_phase(input logic [CfgTimeW-1:0] delay,
                           input logic [CfgTimeW-1:0] interval,
                           input int unsigned cap, input int unsigned pool_size,
                           input int unsigned edge_pct, input int unsigned quota);
    in_t         item;
    int unsigned done;
    program_block(delay, interval);
    foreach (key_pool[i]) key_pool[i] = KeyCodeW'($urandom_range(0, 255));
    done = 0;
    while (done < quota) begin
      item = random_item(cap, pool_size, edge_pct);
      send_item(item);
      // Pointer-button updates are ignored by the block; skip them in the tally.
      if (!(item.opcode == OP_UPDATE && pointer_code(item.key_code))) done++;
    end
  endtask

  initial begin : stimulus
    in_t                 wipe_item;
    logic [KeyCodeW-1:0] pointer_keys [5];
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    board = new();
    pointer_keys[0] = 8'd1;
    pointer_keys[1] = 8'd2;
    pointer_keys[2] = 8'd4;
    pointer_keys[3] = 8'd5;
    pointer_keys[4] = 8'd6;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks at the reset timing: 500 ms delay, 33 ms interval.
    send_update(8'd0,   1'b1, 1'b0, 1'b0, '0);
    // Press and release in one frame: the press wins.
    send_update(8'd255, 1'b1, 1'b1, 1'b1, DeltaMax);
    send_update(8'd255, 1'b0, 1'b1, 1'b0, '0);
    // Pointer buttons: no event, no state change.
    foreach (pointer_keys[i]) send_update(pointer_keys[i], 1'b1, 1'b0, 1'b1, DeltaMax);
    send_update(8'd3, 1'b1, 1'b0, 1'b1, '0);
    // Hit the initial delay exactly, then the interval with a remainder.
    send_update(8'd3, 1'b0, 1'b0, 1'b1, 20'd499999);
    send_update(8'd3, 1'b0, 1'b0, 1'b1, 20'd1);
    send_update(8'd3, 1'b0, 1'b0, 1'b1, 20'd32999);
    send_update(8'd3, 1'b0, 1'b0, 1'b1, DeltaMax);
    // Neither held nor an edge: timer and active bit drop silently.
    send_update(8'd3, 1'b0, 1'b0, 1'b0, DeltaMax);
    send_update(8'd3, 1'b0, 1'b0, 1'b1, DeltaMax);
    // Clear-all with noise in every other field.
    wipe_item               = '1;
    wipe_item.opcode        = OP_CLEAR;
    wipe_item.delta_time_us = DeltaW'($urandom_range(0, 1048575));
    send_item(wipe_item);
    send_update(8'd3,   1'b0, 1'b0, 1'b1, '0);
    send_update(8'd128, 1'b0, 1'b1, 1'b1, 20'd5);

    // Zero delay and interval: every held frame repeats.
    program_block('0, '0);
    send_update(8'd7, 1'b0, 1'b0, 1'b1, '0);
    send_update(8'd7, 1'b0, 1'b0, 1'b1, '0);

    // Pile up one key's timer: with a zero interval nothing is subtracted,
    // so full-size frames accumulate well beyond a maximal interval.
    no_idle = 1'b1;
    send_update(8'd9, 1'b1, 1'b0, 1'b1, '0);
    repeat (PileFrames) send_update(8'd9, 1'b0, 1'b0, 1'b1, DeltaMax);
    no_idle = 1'b0;
    // Now a maximal interval must come off the accumulated value.
    program_block('0, TimeMax);
    repeat (3) send_update(8'd9, 1'b0, 1'b0, 1'b1, '0);
    send_update(8'd9, 1'b0, 1'b1, 1'b0, '0);

    // Random phases across a spread of timing settings.
    run_phase(INITIAL_DELAY_RST, REPEAT_INTERVAL_RST, 200000, 8, 12, 165);
    run_phase('0, '0, 1000, 8, 15, 165);
    run_phase(TimeMax, TimeMax, 1048575, 2, 2, 165);
    run_phase(CfgTimeW'($urandom_range(0, 16777215)), CfgTimeW'($urandom_range(0, 16777215)),
              1048575, 3, 4, 165);
    run_phase(CfgTimeW'($urandom_range(0, 300000)), CfgTimeW'($urandom_range(0, 50000)),
              60000, 6, 10, 165);
    run_phase(TimeMax, '0, 1048575, 2, 3, 165);

    settle();
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
